>>> hdl/nas_pkg.sv
// nas_pkg: shared types and constants for the nearest anchor search core.
// No dependencies.
`default_nettype none
package nas_pkg;
  localparam int MaxAnchors = 1024;
  localparam int CoordBits  = 16;
  localparam int IdxBits    = $clog2(MaxAnchors);
  localparam int CntBits    = $clog2(MaxAnchors + 1);
  localparam int LabelBits  = 16;
  localparam int DistBits   = 17;
  localparam int DiffBits   = CoordBits + 1;
  localparam int SqBits     = 2 * DistBits;
  localparam int SumBits    = SqBits + 2;
  localparam logic [DistBits-1:0] CutoffReset = DistBits'(19434);
  localparam logic [DiffBits:0]   AxisLimit   = (DiffBits+1)'(131071);

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SCAN, ST_DRAIN, ST_SQRT, ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [LabelBits-1:0] item_label;
    logic [CoordBits-1:0] pos_x;
    logic [CoordBits-1:0] pos_y;
    logic [CoordBits-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [LabelBits-1:0] query_label;
    logic [LabelBits-1:0] nearest_label;
    logic [DistBits-1:0]  nearest_distance;
    logic                 found;
  } out_item_t;
endpackage
`default_nettype wire

>>> hdl/nas_if.sv
// nas_if: valid/ready channel carrying one packed item.
// Depends on nas_pkg for payload types.
`default_nettype none
interface nas_in_if;
  logic valid;
  logic ready;
  nas_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nas_out_if;
  logic valid;
  logic ready;
  nas_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/nearest_anchor_search_core.sv
// A query result is built after the item is accepted in these steps: a setup
// state, a scan that reads each stored anchor, a drain of the distance pipe, a
// 19-step square root and a load of the result register.
// The core takes one item at a time; in_ch.ready is high only while idle.
// A waiting result holds only the next query at its output stage.
// Reset clears the anchor count and restores the cutoff; memory is not cleared.
`default_nettype none
module nearest_anchor_search_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  nas_in_if.sink                             in_ch,
  nas_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [nas_pkg::DistBits-1:0]  cfg_data
);
  localparam int CB = nas_pkg::CoordBits;
  localparam int DB = nas_pkg::DiffBits;
  localparam int IB = nas_pkg::IdxBits;
  localparam int NB = nas_pkg::CntBits;
  localparam int LB = nas_pkg::LabelBits;
  localparam int TB = nas_pkg::DistBits;
  localparam int QB = nas_pkg::SqBits;
  localparam int SB = nas_pkg::SumBits;
  localparam int MemW = 3 * CB + LB;

  // anchor memory, one word per anchor
  logic [MemW-1:0] mem [nas_pkg::MaxAnchors];
  logic [MemW-1:0] rd_q;

  nas_pkg::state_t state_r, state_nxt;
  logic [TB-1:0]   cutoff_r;
  logic [NB-1:0]   count_r, count_nxt;
  logic [NB-1:0]   addr_r, addr_nxt;
  nas_pkg::in_item_t  item_r;
  logic            item_ld;
  nas_pkg::out_item_t res_r;
  logic            res_ld;
  logic            ovalid_r, ovalid_nxt;
  logic            mem_we, rd_en;
  logic [IB-1:0]   rd_addr;

  // pipe: v1 read data valid, v2 diffs valid, v3 squares valid
  logic            v1_r, v2_r, v3_r;
  logic [DB-1:0]   dx_r, dy_r, dz_r;
  logic            far_r, far3_r;
  logic [LB-1:0]   lab2_r, lab3_r;
  logic [QB-1:0]   sx_r, sy_r, sz_r;
  logic [SB-1:0]   best_r;
  logic [LB-1:0]   blab_r;
  logic            hit_r;
  logic            clr_best;

  // square root state
  logic [4:0]      sbit_r, sbit_nxt;
  logic [TB+1:0]   root_r;
  logic            sq_start, sq_step;

  assign in_ch.ready = (state_r == nas_pkg::ST_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) cutoff_r <= nas_pkg::CutoffReset;
    else if (cfg_we) cutoff_r <= cfg_data;
  end

  // control sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    ovalid_nxt = ovalid_r;
    item_ld    = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    clr_best   = 1'b0;
    sq_start   = 1'b0;
    sq_step    = 1'b0;
    res_ld     = 1'b0;
    sbit_nxt   = sbit_r;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      nas_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          item_ld   = 1'b1;
          state_nxt = nas_pkg::ST_READ;
        end
      end
      nas_pkg::ST_READ: begin
        state_nxt = nas_pkg::ST_IDLE;
        unique case (nas_pkg::mode_t'(item_r.mode))
          nas_pkg::MODE_LOAD: begin
            if (count_r < NB'(nas_pkg::MaxAnchors)) begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          nas_pkg::MODE_CLEAR: count_nxt = '0;
          nas_pkg::MODE_QUERY: begin
            clr_best  = 1'b1;
            addr_nxt  = '0;
            state_nxt = nas_pkg::ST_SCAN;
          end
          default: ;
        endcase
      end
      nas_pkg::ST_SCAN: begin
        if (addr_r < count_r) begin
          rd_en    = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end else begin
          state_nxt = nas_pkg::ST_DRAIN;
        end
      end
      nas_pkg::ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) begin
          sq_start  = 1'b1;
          sbit_nxt  = 5'd18;
          state_nxt = nas_pkg::ST_SQRT;
        end
      end
      nas_pkg::ST_SQRT: begin
        sq_step  = 1'b1;
        sbit_nxt = sbit_r - 1'b1;
        if (sbit_r == 5'd0) state_nxt = nas_pkg::ST_OUT;
      end
      nas_pkg::ST_OUT: begin
        // wait here while the previous result is still unaccepted
        if (!ovalid_r || out_ch.ready) begin
          res_ld     = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = nas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nas_pkg::ST_IDLE;
    endcase
  end

  assign rd_addr = addr_r[IB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= nas_pkg::ST_IDLE;
      count_r  <= '0;
      addr_r   <= '0;
      ovalid_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      sbit_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      addr_r   <= addr_nxt;
      ovalid_r <= ovalid_nxt;
      v1_r     <= rd_en;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      sbit_r   <= sbit_nxt;
    end
  end

  // anchor memory: write on load, registered read during scan
  always_ff @(posedge clk) begin
    if (mem_we)
      mem[count_r[IB-1:0]] <= {item_r.item_label, item_r.pos_x, item_r.pos_y, item_r.pos_z};
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (item_ld) item_r <= in_ch.data;
  end

  // stage 2: absolute axis differences
  function automatic logic [DB-1:0] absd(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic signed [DB-1:0] d;
    d = DB'(signed'(a)) - DB'(signed'(b));
    return d[DB-1] ? DB'(-d) : DB'(d);
  endfunction

  always_ff @(posedge clk) begin
    dx_r   <= absd(item_r.pos_x, rd_q[3*CB-1:2*CB]);
    dy_r   <= absd(item_r.pos_y, rd_q[2*CB-1:CB]);
    dz_r   <= absd(item_r.pos_z, rd_q[CB-1:0]);
    lab2_r <= rd_q[MemW-1:3*CB];
  end

  // axis limit test; never true at 16-bit coordinates but kept general
  always_comb begin
    far_r = ((DB+1)'(dx_r) > nas_pkg::AxisLimit) || ((DB+1)'(dy_r) > nas_pkg::AxisLimit) ||
            ((DB+1)'(dz_r) > nas_pkg::AxisLimit);
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    sx_r   <= QB'(dx_r) * QB'(dx_r);
    sy_r   <= QB'(dy_r) * QB'(dy_r);
    sz_r   <= QB'(dz_r) * QB'(dz_r);
    lab3_r <= lab2_r;
    far3_r <= far_r;
  end

  // stage 4: sum and compare against best; square root shares best_r
  logic [SB-1:0] d2;
  logic [SB+3:0] trial_sq;
  logic [TB+1:0] trial;
  assign d2 = SB'(sx_r) + SB'(sy_r) + SB'(sz_r);
  assign trial = root_r | ((TB+2)'(1) << sbit_r);
  assign trial_sq = (SB+4)'(trial) * (SB+4)'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (clr_best) begin
      hit_r <= 1'b0;
    end else if (v3_r && !far3_r && d2 < best_r) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_best) begin
      best_r <= SB'(cutoff_r) * SB'(cutoff_r);
      blab_r <= '0;
    end else if (v3_r && !far3_r && d2 < best_r) begin
      best_r <= d2;
      blab_r <= lab3_r;
    end
    if (sq_start) root_r <= '0;
    else if (sq_step && trial_sq <= (SB+4)'(best_r)) root_r <= trial;
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_ld) begin
      res_r.query_label      <= item_r.item_label;
      res_r.nearest_label    <= hit_r ? blab_r : '0;
      res_r.nearest_distance <= hit_r ? root_r[TB-1:0] : cutoff_r;
      res_r.found            <= hit_r;
    end
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NB'(nas_pkg::MaxAnchors)) else $error("anchor count overflow");
  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> addr_r < count_r) else $error("read past anchor count");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ch.ready |=> ovalid_r && $stable(res_r))
    else $error("waiting result dropped or changed");
  a_pipe_empty_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    sq_step |-> !v1_r && !v2_r && !v3_r) else $error("root started before scan drained");
`endif
endmodule
`default_nettype wire
